FILE: hdl/swrs_pkg.sv
// ----------------------------------------------------------------------------
// swrs_pkg
// Shared types and constants for the sliding-window rank selector.
// ----------------------------------------------------------------------------
package swrs_pkg;

  // Field widths of the stream items
  localparam int SCALE_W = 2;
  localparam int VALUE_W = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,   // zeroing pass over the window memory after reset
    ST_IDLE,    // waiting for an input transfer
    ST_SCAN,    // reading the selected ring, one entry per cycle
    ST_DRAIN,   // last read word goes through the insertion stage
    ST_DONE     // result ready to move into the output register
  } state_t;

endpackage

FILE: hdl/sliding_window_rank_select.sv
// ----------------------------------------------------------------------------
// sliding_window_rank_select
// Keeps a ring of the last WINDOW_LEN values per time scale and, per input,
// returns the rank RANK_POS value (ties counted) of its ring, 0 if out of range.
// ----------------------------------------------------------------------------
// Flow: in_tready is high only while idle, so a new item is taken only after
//   the last result has moved into the output register; the single memory
//   read port streams the ring through one compare-insert unit.
// Reset: synchronous active low; afterwards a clearing pass writes zero to all
//   SCALE_COUNT * WINDOW_LEN words of the window memory with in_tready low.
module sliding_window_rank_select #(
  parameter int WINDOW_LEN  = 30,
  parameter int RANK_POS    = 3,
  parameter int SCALE_COUNT = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [swrs_pkg::VALUE_W-1:0] in_tdata,   // [15:0] new_value
  input  logic [swrs_pkg::SCALE_W-1:0] in_tuser,   // [1:0] scale_index
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swrs_pkg::VALUE_W-1:0] out_tdata   // [15:0] low_quantile
);

  import swrs_pkg::*;

  localparam int DEPTH    = SCALE_COUNT * WINDOW_LEN;
  localparam int AW       = $clog2(DEPTH);
  localparam int PW       = $clog2(WINDOW_LEN);
  localparam int SW       = (SCALE_COUNT > 1) ? $clog2(SCALE_COUNT) : 1;
  localparam int RANK_EFF = (RANK_POS >= WINDOW_LEN) ? WINDOW_LEN - 1 : RANK_POS;
  localparam int KD       = RANK_EFF + 1;

  state_t state_r, state_nxt;

  // window memory and per-scale write pointers
  logic [VALUE_W-1:0] mem_r [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [PW-1:0]      ptr_r [SCALE_COUNT];

  // sequencer counters and flags
  logic [AW-1:0]      clr_addr_r;
  logic [PW-1:0]      iss_cnt_r;
  logic               ins_vld_r;
  logic               bad_r;

  // sorted buffer of the KD smallest values seen so far
  logic [VALUE_W-1:0] buf_r    [KD];
  logic [VALUE_W-1:0] buf_nxt  [KD];
  logic [KD-1:0]      bvalid_r;
  logic [KD-1:0]      bvalid_nxt;
  logic [KD-1:0]      keep;

  // output register
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_data_r;

  // input decode
  logic               in_xfer;
  logic               scale_ok;
  logic [SW-1:0]      scale_idx;
  logic [PW-1:0]      ptr_cur;
  logic [PW-1:0]      ptr_eff;
  logic [PW-1:0]      ptr_next;
  logic [AW-1:0]      base_addr;
  logic               load_out;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign scale_ok   = 32'(in_tuser) < SCALE_COUNT;
  assign scale_idx  = SW'(in_tuser);
  assign ptr_cur    = ptr_r[scale_idx];
  assign ptr_eff    = (32'(ptr_cur) >= WINDOW_LEN) ? '0 : ptr_cur;
  assign ptr_next   = (32'(ptr_eff) == WINDOW_LEN - 1) ? '0 : ptr_eff + PW'(1);
  assign base_addr  = AW'(32'(in_tuser) * WINDOW_LEN);
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // memory write port: zeroing pass, or the new value at accept of a valid scale
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_xfer && scale_ok) begin
      mem_we    = 1'b1;
      mem_waddr = base_addr + AW'(ptr_eff);
      mem_wdata = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[rd_addr_r];
  end

  // next state and read address
  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          rd_addr_nxt = base_addr;
          state_nxt   = scale_ok ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        rd_addr_nxt = rd_addr_r + AW'(1);
        if (32'(iss_cnt_r) == WINDOW_LEN - 1) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      iss_cnt_r  <= '0;
      ins_vld_r  <= 1'b0;
      bad_r      <= 1'b0;
      rd_addr_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_addr_r <= rd_addr_nxt;
      ins_vld_r <= (state_r == ST_SCAN);
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (in_xfer) begin
        iss_cnt_r <= '0;
        bad_r     <= !scale_ok;
      end else if (state_r == ST_SCAN) begin
        iss_cnt_r <= iss_cnt_r + PW'(1);
      end
    end
  end

  // write pointers advance and wrap on each accepted item of a valid scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SCALE_COUNT; s++) ptr_r[s] <= '0;
    end else if (in_xfer && scale_ok) begin
      ptr_r[scale_idx] <= ptr_next;
    end
  end

  // compare-insert unit: one read word is placed into the sorted buffer
  genvar g;
  generate
    for (g = 0; g < KD; g++) begin : g_ins
      assign keep[g] = bvalid_r[g] && (buf_r[g] <= rd_data_r);
      if (g == 0) begin : g_head
        assign buf_nxt[g]    = keep[g] ? buf_r[g] : rd_data_r;
        assign bvalid_nxt[g] = 1'b1;
      end else begin : g_tail
        assign buf_nxt[g]    = keep[g]     ? buf_r[g]   :
                               keep[g - 1] ? rd_data_r  : buf_r[g - 1];
        assign bvalid_nxt[g] = bvalid_r[g] | bvalid_r[g - 1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
    end else if (in_xfer) begin
      bvalid_r <= '0;
    end else if (ins_vld_r) begin
      bvalid_r <= bvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_vld_r) begin
      for (int k = 0; k < KD; k++) buf_r[k] <= buf_nxt[k];
    end
  end

  // output register, parts the sequencer from the result channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= bad_r ? '0 : buf_r[KD - 1];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mem_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR) || in_xfer)
    else $error("window memory written outside clear pass or accept");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && scale_ok) |-> (32'(ptr_cur) < WINDOW_LEN))
    else $error("write pointer out of range");

  a_buf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !bad_r) |-> bvalid_r[KD - 1])
    else $error("rank buffer not full at end of scan");

  a_ins_window: assert property (@(posedge clk) disable iff (!rst_n)
    ins_vld_r |-> (state_r == ST_SCAN) || (state_r == ST_DRAIN))
    else $error("insertion outside scan");

endmodule
